/* hw/rtl/compass_heading_atan2_defines.svh */
// Assertion macros for the checker file (cha_checker.sv) of the compass heading block.
`ifndef COMPASS_HEADING_ATAN2_DEFINES_SVH
`define COMPASS_HEADING_ATAN2_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("compass heading check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("compass heading check failed");

`endif

/* hw/rtl/cha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cha_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_FRAC  = 32;
    localparam int VEC_SCALE = 40;
    localparam int VEC_W     = 60;
    localparam int ACC_W     = 36;
    localparam int DIFF_W    = 18;

    localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 2'd3;

    localparam logic [CFG_W-1:0] X_LOW_RESET  = 16'hFD51;
    localparam logic [CFG_W-1:0] X_HIGH_RESET = 16'hFEFC;
    localparam logic [CFG_W-1:0] Y_LOW_RESET  = 16'h0027;
    localparam logic [CFG_W-1:0] Y_HIGH_RESET = 16'h01B1;

    localparam logic [ACC_W-1:0] PI_ACC = 36'd13493037705;
    localparam logic [OUT_W-1:0] HEADING_MAX = 16'h7FFF;
    localparam logic [OUT_W-1:0] HEADING_MIN = 16'h8000;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [VEC_W-1:0] x;
        logic [VEC_W-1:0] y;
        logic [ACC_W-1:0] z;
    } cha_cell_t;

    function automatic logic [ACC_W-1:0] atan_value(input int idx);
        logic [ACC_W-1:0] v;
        case (idx)
            0:       v = 36'd3373259426;
            1:       v = 36'd1991351318;
            2:       v = 36'd1052175346;
            3:       v = 36'd534100635;
            4:       v = 36'd268086748;
            5:       v = 36'd134174063;
            6:       v = 36'd67103403;
            7:       v = 36'd33553749;
            8:       v = 36'd16777131;
            9:       v = 36'd8388597;
            10:      v = 36'd4194303;
            11:      v = 36'd2097152;
            12:      v = 36'd1048576;
            13:      v = 36'd524288;
            14:      v = 36'd262144;
            15:      v = 36'd131072;
            16:      v = 36'd65536;
            17:      v = 36'd32768;
            18:      v = 36'd16384;
            19:      v = 36'd8192;
            20:      v = 36'd4096;
            21:      v = 36'd2048;
            22:      v = 36'd1024;
            23:      v = 36'd512;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cha_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module cha_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    advance,
    input  wire logic                    in_valid,
    input  wire logic [cha_pkg::IN_W-1:0]  x_sample,
    input  wire logic [cha_pkg::IN_W-1:0]  y_sample,
    input  wire logic [cha_pkg::CFG_W-1:0] x_low,
    input  wire logic [cha_pkg::CFG_W-1:0] x_high,
    input  wire logic [cha_pkg::CFG_W-1:0] y_low,
    input  wire logic [cha_pkg::CFG_W-1:0] y_high,
    output cha_pkg::cha_cell_t           cell_out
);
    import cha_pkg::*;

    logic signed [CFG_W:0]    x_sum;
    logic signed [CFG_W:0]    y_sum;
    logic signed [CFG_W:0]    x_off;
    logic signed [CFG_W:0]    y_off;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] vx;
    logic signed [DIFF_W-1:0] vy;
    logic                     dx_neg;
    logic                     dy_neg;
    cha_cell_t                cell_next;
    cha_cell_t                cell_reg;

    // Offsets are (high + low) / 2, truncated toward zero.
    assign x_sum = $signed({x_high[CFG_W-1], x_high}) + $signed({x_low[CFG_W-1], x_low});
    assign y_sum = $signed({y_high[CFG_W-1], y_high}) + $signed({y_low[CFG_W-1], y_low});
    assign x_off = (x_sum + $signed({{CFG_W{1'b0}}, x_sum[CFG_W]})) >>> 1;
    assign y_off = (y_sum + $signed({{CFG_W{1'b0}}, y_sum[CFG_W]})) >>> 1;

    assign dx = $signed({{(DIFF_W-IN_W){x_sample[IN_W-1]}}, x_sample})
              - $signed({{(DIFF_W-CFG_W-1){x_off[CFG_W]}}, x_off});
    assign dy = $signed({{(DIFF_W-IN_W){y_sample[IN_W-1]}}, y_sample})
              - $signed({{(DIFF_W-CFG_W-1){y_off[CFG_W]}}, y_off});

    assign dx_neg = dx[DIFF_W-1];
    assign dy_neg = dy[DIFF_W-1];
    assign vx     = dx_neg ? -dx : dx;
    assign vy     = dx_neg ? -dy : dy;

    always_comb begin
        cell_next.valid = in_valid;
        cell_next.zero  = (dx == '0) && (dy == '0);
        cell_next.x     = {{(VEC_W-DIFF_W-VEC_SCALE){vx[DIFF_W-1]}}, vx, {VEC_SCALE{1'b0}}};
        cell_next.y     = {{(VEC_W-DIFF_W-VEC_SCALE){vy[DIFF_W-1]}}, vy, {VEC_SCALE{1'b0}}};
        if (!dx_neg) begin
            cell_next.z = '0;
        end else if (dy_neg) begin
            cell_next.z = -PI_ACC;
        end else begin
            cell_next.z = PI_ACC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (advance) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

/* hw/rtl/cha_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module cha_cell #(
    parameter int STAGE_IDX = 0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          advance,
    input  wire cha_pkg::cha_cell_t cell_in,
    output cha_pkg::cha_cell_t cell_out
);
    import cha_pkg::*;

    localparam logic [ACC_W-1:0] ATAN_STEP = atan_value(STAGE_IDX);

    logic signed [VEC_W-1:0] x_in;
    logic signed [VEC_W-1:0] y_in;
    logic signed [VEC_W-1:0] x_sh;
    logic signed [VEC_W-1:0] y_sh;
    cha_cell_t               cell_next;
    cha_cell_t               cell_reg;

    assign x_in = cell_in.x;
    assign y_in = cell_in.y;
    assign x_sh = x_in >>> STAGE_IDX;
    assign y_sh = y_in >>> STAGE_IDX;

    always_comb begin
        cell_next.valid = cell_in.valid;
        cell_next.zero  = cell_in.zero;
        if (!y_in[VEC_W-1]) begin
            cell_next.x = x_in + y_sh;
            cell_next.y = y_in - x_sh;
            cell_next.z = cell_in.z + ATAN_STEP;
        end else begin
            cell_next.x = x_in - y_sh;
            cell_next.y = y_in + x_sh;
            cell_next.z = cell_in.z - ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (advance) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

/* hw/rtl/cha_round.sv */
`timescale 1ns / 1ps
`default_nettype none

module cha_round #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire logic [cha_pkg::ACC_W-1:0] z,
    input  wire logic                      zero,
    output logic      [cha_pkg::OUT_W-1:0] heading
);
    import cha_pkg::*;

    localparam int               SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF  = ACC_W'(1) << (SHIFT - 1);

    logic             z_neg;
    logic [ACC_W-1:0] z_clamp;
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] rounded;

    assign z_neg = z[ACC_W-1];

    always_comb begin
        if (!z_neg && (z > PI_ACC)) begin
            z_clamp = PI_ACC;
        end else if (z_neg && ($signed(z) < $signed(-PI_ACC))) begin
            z_clamp = -PI_ACC;
        end else begin
            z_clamp = z;
        end
    end

    assign mag     = z_neg ? -z_clamp : z_clamp;
    assign rounded = (mag + HALF) >> SHIFT;

    always_comb begin
        if (zero) begin
            heading = '0;
        end else if (!z_neg) begin
            if (rounded > {{(ACC_W-OUT_W){1'b0}}, HEADING_MAX}) begin
                heading = HEADING_MAX;
            end else begin
                heading = rounded[OUT_W-1:0];
            end
        end else begin
            if (rounded > {{(ACC_W-OUT_W){1'b0}}, HEADING_MIN}) begin
                heading = HEADING_MIN;
            end else begin
                heading = -rounded[OUT_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/compass_heading_atan2.sv */
`timescale 1ns / 1ps
`default_nettype none

// Hard-iron corrected compass heading. Each transaction on the s_ side carries one X/Y
// magnetometer sample; the block subtracts the offsets (high + low) / 2 taken from the
// calibration registers and returns atan2(dy, dx) on the m_ side as a signed angle in
// radians with ANGLE_FRAC_BITS fraction bits, or 0 for a zero vector. The angle comes
// from a row of CORDIC_STAGES vectoring cells, one rotation per cell, so the block
// accepts one sample every cycle unless the output is held off; each result passes through
// the input register, the cells and the output register. When the output is held off
// the whole row stalls together. Calibration registers should be written only while no
// sample is in flight.
module compass_heading_atan2 #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [cha_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cha_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // x_sample [15:0], y_sample [31:16]
    input  wire logic [2*cha_pkg::IN_W-1:0]         s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // heading [15:0]
    output logic      [cha_pkg::OUT_W-1:0]          m_tdata
);
    import cha_pkg::*;

    logic [CFG_W-1:0] x_low_reg;
    logic [CFG_W-1:0] x_high_reg;
    logic [CFG_W-1:0] y_low_reg;
    logic [CFG_W-1:0] y_high_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [OUT_W-1:0] heading_next;
    logic             advance;
    cha_cell_t        chain [0:CORDIC_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_low_reg  <= X_LOW_RESET;
            x_high_reg <= X_HIGH_RESET;
            y_low_reg  <= Y_LOW_RESET;
            y_high_reg <= Y_HIGH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_X_LOW:  x_low_reg  <= cfg_data;
                REG_X_HIGH: x_high_reg <= cfg_data;
                REG_Y_LOW:  y_low_reg  <= cfg_data;
                REG_Y_HIGH: y_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    cha_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (s_tvalid),
        .x_sample (s_tdata[IN_W-1:0]),
        .y_sample (s_tdata[2*IN_W-1:IN_W]),
        .x_low    (x_low_reg),
        .x_high   (x_high_reg),
        .y_low    (y_low_reg),
        .y_high   (y_high_reg),
        .cell_out (chain[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        cha_cell #(
            .STAGE_IDX (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    cha_round #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_round (
        .z       (chain[CORDIC_STAGES].z),
        .zero    (chain[CORDIC_STAGES].zero),
        .heading (heading_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= chain[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= heading_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/cha_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "compass_heading_atan2_defines.svh"

module cha_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [cha_pkg::OUT_W-1:0]     m_tdata
);
    import cha_pkg::*;

    // The output register is empty in the first cycle after reset.
    `CHA_ASSERT_SAME(a_idle_after_reset, aclk, aresetn, !$past(aresetn), !m_tvalid)
    // An empty output register never holds off the input side.
    `CHA_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)
    // A blocked result stalls the whole pipeline, input included.
    `CHA_ASSERT_SAME(a_stall_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    // A blocked result stays and holds its value.
    `CHA_ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind compass_heading_atan2 cha_checker u_cha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* sim/compass_heading_atan2_checker.sv */
`timescale 1ns / 1ps

module compass_heading_atan2_checker #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [cha_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cha_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    // x_sample [15:0], y_sample [31:16]
    input  wire logic [2*cha_pkg::IN_W-1:0]    s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // heading [15:0]
    input  wire logic [cha_pkg::OUT_W-1:0]     m_tdata,
    output int                                 mismatches,
    output int                                 headings_checked
);

    import cha_pkg::*;

    typedef struct {
        logic signed [IN_W-1:0]  x_sample;
        logic signed [IN_W-1:0]  y_sample;
        logic signed [OUT_W-1:0] heading;
    } heading_expect_t;

    heading_expect_t pending_headings[$];

    logic signed [CFG_W-1:0] cal_x_low;
    logic signed [CFG_W-1:0] cal_x_high;
    logic signed [CFG_W-1:0] cal_y_low;
    logic signed [CFG_W-1:0] cal_y_high;

    longint atan_step [24] = '{
        64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
        64'sd268086748,  64'sd134174063,  64'sd67103403,   64'sd33553749,
        64'sd16777131,   64'sd8388597,    64'sd4194303,    64'sd2097152,
        64'sd1048576,    64'sd524288,     64'sd262144,     64'sd131072,
        64'sd65536,      64'sd32768,      64'sd16384,      64'sd8192,
        64'sd4096,       64'sd2048,       64'sd1024,       64'sd512
    };

    function automatic logic signed [OUT_W-1:0] predict_heading(
        input logic signed [IN_W-1:0] xs,
        input logic signed [IN_W-1:0] ys
    );
        longint half_turn;
        longint dx;
        longint dy;
        longint vx;
        longint vy;
        longint angle;
        longint x_part;
        longint y_part;
        longint mag;
        longint rounded;
        int     drop;
        int     i;
        half_turn = longint'(PI_ACC);
        drop = ACC_FRAC - ANGLE_FRAC_BITS;
        dx = longint'(xs) - (longint'(cal_x_high) + longint'(cal_x_low)) / 2;
        dy = longint'(ys) - (longint'(cal_y_high) + longint'(cal_y_low)) / 2;
        if (dx == 0 && dy == 0) begin
            return '0;
        end
        angle = 0;
        // Vectors in the left half plane are turned through half a circle first.
        if (dx < 0) begin
            angle = (dy >= 0) ? half_turn : -half_turn;
            dx = -dx;
            dy = -dy;
        end
        vx = dx <<< VEC_SCALE;
        vy = dy <<< VEC_SCALE;
        for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            x_part = vx >>> i;
            y_part = vy >>> i;
            if (vy >= 0) begin
                vx = vx + y_part;
                vy = vy - x_part;
                angle = angle + atan_step[i];
            end else begin
                vx = vx - y_part;
                vy = vy + x_part;
                angle = angle - atan_step[i];
            end
        end
        if (angle > half_turn) begin
            angle = half_turn;
        end
        if (angle < -half_turn) begin
            angle = -half_turn;
        end
        mag = (angle < 0) ? -angle : angle;
        mag = (mag + (64'sd1 <<< (drop - 1))) >>> drop;
        rounded = (angle < 0) ? -mag : mag;
        if (rounded > 32767) begin
            rounded = 32767;
        end
        if (rounded < -32768) begin
            rounded = -32768;
        end
        return rounded[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] %s", $time, what);
    endtask

    always @(posedge aclk) begin : watch
        heading_expect_t   want;
        logic signed [OUT_W-1:0] got;
        if (!aresetn) begin
            cal_x_low  = X_LOW_RESET;
            cal_x_high = X_HIGH_RESET;
            cal_y_low  = Y_LOW_RESET;
            cal_y_high = Y_HIGH_RESET;
            pending_headings.delete();
            mismatches = 0;
            headings_checked <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                headings_checked <= headings_checked + 1;
                if (pending_headings.size() == 0) begin
                    report_mismatch($sformatf("heading %0d with no sample outstanding", got));
                end else begin
                    want = pending_headings.pop_front();
                    if (got !== want.heading) begin
                        report_mismatch($sformatf(
                            "heading for x=%0d y=%0d: got %0d, expected %0d",
                            want.x_sample, want.y_sample, got, want.heading));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want.x_sample = s_tdata[IN_W-1:0];
                want.y_sample = s_tdata[2*IN_W-1:IN_W];
                want.heading  = predict_heading(want.x_sample, want.y_sample);
                pending_headings.push_back(want);
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_X_LOW: begin
                        cal_x_low = cfg_data;
                    end
                    REG_X_HIGH: begin
                        cal_x_high = cfg_data;
                    end
                    REG_Y_LOW: begin
                        cal_y_low = cfg_data;
                    end
                    REG_Y_HIGH: begin
                        cal_y_high = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

/* sim/tb_compass_heading_atan2.sv */
`timescale 1ns / 1ps

module tb_compass_heading_atan2;

    import cha_pkg::*;

    localparam int STAGES       = 16;
    localparam int FRAC_BITS    = 13;
    localparam int DRAIN_CYCLES = STAGES + 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 300000;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [2*IN_W-1:0]      s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;

    int  mismatches;
    int  headings_checked;
    int  samples_sent = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_active = 1'b0;

    int cal_x_low;
    int cal_x_high;
    int cal_y_low;
    int cal_y_high;

    compass_heading_atan2 #(
        .CORDIC_STAGES  (STAGES),
        .ANGLE_FRAC_BITS(FRAC_BITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    compass_heading_atan2_checker #(
        .CORDIC_STAGES  (STAGES),
        .ANGLE_FRAC_BITS(FRAC_BITS)
    ) heading_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .headings_checked(headings_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("compass_heading_atan2 test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end

    // A single long hold-off on the result side, so that the pipeline fills and
    // back-pressure reaches the sample side.
    initial begin
        do @(posedge aclk); while (!hold_request);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_index <= index;
        cfg_data  <= value[CFG_W-1:0];
        cfg_we    <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic load_calibration(input int xl, input int xh, input int yl, input int yh);
        cal_x_low  = xl;
        cal_x_high = xh;
        cal_y_low  = yl;
        cal_y_high = yh;
        write_reg(REG_X_LOW, xl);
        write_reg(REG_X_HIGH, xh);
        write_reg(REG_Y_LOW, yl);
        write_reg(REG_Y_HIGH, yh);
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input int x, input int y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y[IN_W-1:0], x[IN_W-1:0]};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (headings_checked < samples_sent) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_sample();
        int x_centre;
        int y_centre;
        int d;
        x_centre = (cal_x_high + cal_x_low) / 2;
        y_centre = (cal_y_high + cal_y_low) / 2;
        case ($urandom_range(9))
            0, 1, 2: begin
                send_sample(int'($urandom_range(65535)), int'($urandom_range(65535)));
            end
            3, 4, 5: begin
                send_sample(x_centre + int'($urandom_range(600)) - 300,
                            y_centre + int'($urandom_range(600)) - 300);
            end
            6: begin
                send_sample(x_centre, y_centre + int'($urandom_range(65535)) - 32768);
            end
            7: begin
                send_sample(x_centre + int'($urandom_range(65535)) - 32768, y_centre);
            end
            8: begin
                send_sample(x_centre, y_centre);
            end
            default: begin
                d = int'($urandom_range(20000, 1));
                send_sample($urandom_range(1) ? x_centre + d : x_centre - d,
                            $urandom_range(1) ? y_centre + d : y_centre - d);
            end
        endcase
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count,
                                    input bit wide_cal, input bit long_hold);
        int i;
        send_idle_pct  <= idle_pct;
        recv_stall_pct <= stall_pct;
        if (long_hold) begin
            hold_request <= 1'b1;
        end
        if (wide_cal) begin
            load_calibration(int'($urandom_range(65535)) - 32768,
                             int'($urandom_range(65535)) - 32768,
                             int'($urandom_range(65535)) - 32768,
                             int'($urandom_range(65535)) - 32768);
        end else begin
            load_calibration(-int'($urandom_range(3000)), int'($urandom_range(3000)),
                             -int'($urandom_range(3000)), int'($urandom_range(3000)));
        end
        for (i = 0; i < count; i++) begin
            send_random_sample();
        end
        wait_drained();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cal_x_low  = -687;
        cal_x_high = -260;
        cal_y_low  = 39;
        cal_y_high = 433;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset calibration: the centre is x = -473, y = 236.
        send_sample(-473, 236);
        send_sample(-32768, 236);
        send_sample(-474, 236);
        send_sample(-474, 235);
        send_sample(-1000, -1000);
        send_sample(32767, 236);
        send_sample(-473, 32767);
        send_sample(-473, -32768);
        send_sample(32767, 32767);
        send_sample(-32768, -32768);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        wait_drained();

        // Full-range limits: the X centre truncates to zero, the Y centre sits at the top.
        load_calibration(-32768, 32767, 32767, 32767);
        send_sample(0, -32768);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(-1, 32767);
        send_sample(0, 32767);
        wait_drained();

        // Limits swapped on Y and X pinned at the bottom.
        load_calibration(-32768, -32768, 32767, -32768);
        send_sample(32767, 0);
        send_sample(32767, -32768);
        send_sample(-32768, 1);
        send_sample(-32768, 0);
        send_sample(-32768, -32768);
        wait_drained();

        run_random_phase(0, 0, 160, 1'b0, 1'b0);
        run_random_phase(59, 0, 160, 1'b1, 1'b0);
        run_random_phase(0, 59, 160, 1'b0, 1'b0);
        run_random_phase(35, 35, 160, 1'b1, 1'b0);
        run_random_phase(0, 0, 90, 1'b0, 1'b1);

        if (mismatches == 0) begin
            $display("compass_heading_atan2 test passed");
        end else begin
            $display("compass_heading_atan2 test failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/cha_pkg.sv
hw/rtl/cha_front.sv
hw/rtl/cha_cell.sv
hw/rtl/cha_round.sv
hw/rtl/compass_heading_atan2.sv
hw/rtl/cha_checker.sv
sim/compass_heading_atan2_checker.sv
sim/tb_compass_heading_atan2.sv
